// ===== rtl/core/lfrb_pkg.sv =====
`default_nettype none
// ============================================================================
// lfrb_pkg
// Shared types and codes for the lockable field register bank.
// ============================================================================
package lfrb_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned START_W   = 5;
    localparam int unsigned FWIDTH_W  = 6;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned HALF_SHIFT = 16;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_LOCK  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    localparam logic [2:0] TYPE_RW     = 3'd0;
    localparam logic [2:0] TYPE_RO     = 3'd1;
    localparam logic [2:0] TYPE_L16    = 3'd2;
    localparam logic [2:0] TYPE_L31    = 3'd3;
    localparam logic [2:0] TYPE_R16W16 = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0]   write_data;
        logic [FWIDTH_W-1:0] field_width;
        logic [START_W-1:0]  field_lsb;
        logic [2:0]          field_type;
        logic [IDX_W-1:0]    register_index;
        cmd_t                command;
    } req_t;

    typedef struct packed {
        logic              status;
        logic              lock_state;
        logic [WORD_W-1:0] read_data;
    } rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wr_value;
    } upd_t;

endpackage : lfrb_pkg
`default_nettype wire

// ===== rtl/core/lfrb_field_unit.sv =====
`default_nettype none
// ============================================================================
// lfrb_field_unit
// Field access logic: masks, lock checks and read-modify-write of one register.
// ============================================================================
module lfrb_field_unit
(
    input  wire lfrb_pkg::req_t    req,
    input  wire logic [31:0]       reg_value,
    input  wire logic              in_range,
    output lfrb_pkg::rsp_t         rsp,
    output lfrb_pkg::upd_t         upd
);
    import lfrb_pkg::*;

    logic [31:0] wmask;
    logic [63:0] fmask_wide;
    logic [31:0] fmask;
    logic [63:0] data_wide;
    logic        low_half;
    logic [4:0]  l16_pos;
    logic        locked;
    logic        writable;

    always_comb
    begin
        if (req.field_width >= 6'd32)
        begin
            wmask = '1;
        end
        else
        begin
            wmask = (32'd1 << req.field_width[4:0]) - 32'd1;
        end
        fmask_wide = {32'd0, wmask} << req.field_lsb;
        fmask      = fmask_wide[31:0];
        data_wide  = {32'd0, req.write_data & wmask} << req.field_lsb;
        low_half   = !req.field_lsb[4];
        l16_pos    = low_half ? {1'b1, req.field_lsb[3:0]} : req.field_lsb;

        case (req.field_type)
            TYPE_L16: locked = reg_value[l16_pos];
            TYPE_L31: locked = reg_value[31];
            default:  locked = 1'b0;
        endcase

        case (req.field_type)
            TYPE_L16, TYPE_L31: writable = !locked;
            TYPE_R16W16:        writable = low_half;
            TYPE_RW:            writable = 1'b1;
            default:            writable = 1'b0;
        endcase
    end

    always_comb
    begin
        rsp          = '0;
        upd.wr_en    = 1'b0;
        upd.wr_value = reg_value;
        if (!in_range)
        begin
            rsp.status = (req.command == CMD_SET) || (req.command == CMD_LOCK);
        end
        else
        begin
            case (req.command)
                CMD_GET:
                begin
                    rsp.read_data = (reg_value & fmask) >> req.field_lsb;
                end
                CMD_SET:
                begin
                    if (writable)
                    begin
                        upd.wr_en    = 1'b1;
                        upd.wr_value = (reg_value & ~fmask) | data_wide[31:0];
                    end
                    else
                    begin
                        rsp.status = 1'b1;
                    end
                end
                CMD_LOCK:
                begin
                    if (req.field_type == TYPE_L16)
                    begin
                        upd.wr_en    = 1'b1;
                        upd.wr_value = low_half ? (reg_value | {fmask[15:0], 16'd0})
                                                : (reg_value | fmask);
                    end
                    else if (req.field_type == TYPE_L31)
                    begin
                        upd.wr_en    = 1'b1;
                        upd.wr_value = reg_value | 32'h8000_0000;
                    end
                    else
                    begin
                        rsp.status = 1'b1;
                    end
                end
                default:
                begin
                    rsp.lock_state = locked;
                end
            endcase
        end
    end

endmodule : lfrb_field_unit
`default_nettype wire

// ===== rtl/core/lockable_field_register_bank_core.sv =====
`default_nettype none
// ============================================================================
// lockable_field_register_bank_core
// Bank of 32-bit control registers with per-field lock policies.
// ============================================================================
// One access is taken per clock cycle unless back-pressure stalls the bank. An
// accepted access sits in the input register, where the addressed register is
// read, checked and rewritten in a single pass; its result then lands in the
// output register, from which it is offered and held until it is taken. The
// bank is flip-flops cleared by reset; registers at or above NUM_REGS read as
// zero and refuse set and lock. Back-pressure on the result side stalls both
// stages.
module lockable_field_register_bank_core
#(
    parameter int NUM_REGS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[1:0], register_index[5:2], field_type[8:6], field_lsb[13:9],
    // field_width[19:14], write_data[51:20], zero[55:52]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[31:0], lock_state[32], status[33], zero[39:34]
    output logic [39:0]      m_tdata
);
    import lfrb_pkg::*;

    localparam int DEPTH = (NUM_REGS < 16) ? NUM_REGS : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] bank_reg [DEPTH];
    req_t        s1_reg;
    logic        s1_valid_reg;
    rsp_t        out_reg;
    logic        out_valid_reg;

    logic        advance;
    logic        in_range;
    logic [AW-1:0] addr;
    logic [31:0] cur_value;
    rsp_t        rsp;
    upd_t        upd;

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign in_range = ({28'd0, s1_reg.register_index} < 32'(DEPTH));
    assign addr     = s1_reg.register_index[AW-1:0];
    assign cur_value = in_range ? bank_reg[addr] : 32'd0;

    lfrb_field_unit u_field
    (
        .req       (s1_reg),
        .reg_value (cur_value),
        .in_range  (in_range),
        .rsp       (rsp),
        .upd       (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_reg <= req_t'(s_tdata[51:0]);
        end
        if (advance)
        begin
            out_reg <= rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                bank_reg[i] <= '0;
            end
        end
        else if (advance && upd.wr_en && in_range)
        begin
            bank_reg[addr] <= upd.wr_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule : lockable_field_register_bank_core
`default_nettype wire

// ===== rtl/core/lfrb_checker.sv =====
`default_nettype none
// ============================================================================
// lfrb_checker
// Port-level checks on the register bank stream interface.
// ============================================================================
module lfrb_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("accepted access produced no result");

    a_read_only_get: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[31:0] != 32'd0)) |-> (m_tdata[33:32] == 2'b00))
        else $error("nonzero read data with lock or status set");

    a_lock_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[32]) |-> ((m_tdata[31:0] == 32'd0) && !m_tdata[33]))
        else $error("lock state set with data or error");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result transfer changed");

endmodule : lfrb_checker

bind lockable_field_register_bank_core lfrb_checker u_lfrb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
